>>> sv/synth_tuning_word_sequencer_unit_defines.svh
// Assertion macros shared by the tuning word sequencer RTL.
`ifndef SYNTH_TUNING_WORD_SEQUENCER_UNIT_DEFINES_SVH
`define SYNTH_TUNING_WORD_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every rising edge outside reset.
`define STWS_ASSERT(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
		else $error("stws assertion failed");
// Check that a condition holds in the cycle after another.
`define STWS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("stws assertion failed");
`else
`define STWS_ASSERT(lbl, clk_i, rstn_i, prop)
`define STWS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

>>> sv/stws_pkg.sv
// Types, constants and helpers shared by the tuning word sequencer.
package stws_pkg;

	localparam int unsigned FREQ_W      = 24;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [23:0] FREQ_CAP      = 24'd9999999;
	localparam logic [23:0] MIN_FREQ_RST  = 24'd0;
	localparam logic [23:0] MAX_FREQ_RST  = 24'd2999999;

	// Reciprocal of ten, exact for operands below 2**26
	localparam logic [23:0] RECIP10      = 24'hCCCCCD;
	localparam int unsigned RECIP_SHIFT  = 27;
	localparam int unsigned QUOT_W       = 21;

	localparam logic [7:0]  BAND_AUTO     = 8'hFF;
	localparam logic [7:0]  BAND_SPLIT    = 8'd6;
	localparam logic [7:0]  DIGIT_BASE    = 8'd112;
	localparam logic [9:0]  KHZ_FOLD      = 10'd500;
	localparam logic [10:0] KHZ_BASE      = 11'd560;
	localparam logic [9:0]  THOUSAND      = 10'd1000;
	localparam logic [11:0] SYN2_LOW_ADD  = 12'd12;
	localparam logic [11:0] SYN2_HIGH_SUB = 12'd18;

	localparam logic [7:0] LATCH_A3 = 8'h30;
	localparam logic [7:0] LATCH_A2 = 8'h20;
	localparam logic [7:0] LATCH_A1 = 8'h10;

	// Result targets
	localparam logic [2:0] TGT_BAND   = 3'd0;
	localparam logic [2:0] TGT_SYN1   = 3'd1;
	localparam logic [2:0] TGT_SYN2   = 3'd2;
	localparam logic [2:0] TGT_PRESET = 3'd3;
	localparam logic [2:0] TGT_DATA   = 3'd4;

	// Configuration register select, paddr bit 2
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;
	localparam logic        REG_MIN  = 1'b0;
	localparam logic        REG_MAX  = 1'b1;

	typedef struct packed {
		logic [23:0] frequency;
		logic        force_req;
		logic [7:0]  band_override;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [7:0]  data;
		logic [23:0] clamped_frequency;
		logic        last;
	} out_item_t;

	// One classified item handed from front to back
	typedef struct packed {
		logic [23:0] clamped_frequency;
		logic [7:0]  band;
		logic [10:0] khz;
		logic [7:0]  syn2_hi;
		logic [3:0]  syn2_lo;
		logic [3:0]  ones;
		logic [3:0]  hundreds;
		logic        wr_band;
		logic        wr_syn1;
		logic        wr_syn2;
		logic        wr_preset;
	} desc_t;

	function automatic logic [7:0] auto_band(input logic [23:0] f);
		logic [7:0] b;
		if (f < 24'd250000)       b = 8'd1;
		else if (f < 24'd400000)  b = 8'd2;
		else if (f < 24'd750000)  b = 8'd3;
		else if (f < 24'd1050000) b = 8'd4;
		else if (f < 24'd1450000) b = 8'd5;
		else if (f < 24'd1850000) b = 8'd6;
		else if (f < 24'd2150000) b = 8'd7;
		else if (f < 24'd2500000) b = 8'd8;
		else                      b = 8'd9;
		return b;
	endfunction

endpackage

>>> sv/stws_fifo.sv
// Small register queue of classified items between front and back.
module stws_fifo #(
	parameter int unsigned Depth = stws_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  stws_pkg::desc_t wr_data,
	output logic           full,
	input  logic           pop,
	output stws_pkg::desc_t rd_data,
	output logic           empty
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	stws_pkg::desc_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/stws_front.sv
// Front end: clamp, decimal split, band pick and change detection per item.
module stws_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  stws_pkg::in_item_t item,
	input  logic [23:0]        lo_lim,
	input  logic [23:0]        hi_lim,
	output logic               q_push,
	input  logic               q_full,
	output stws_pkg::desc_t    q_desc
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CLAMP = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_FINAL = 4'b1000
	} front_state_t;

	localparam logic [2:0] DivLast = 3'd4;

	front_state_t state_q;
	logic [2:0]   step_q;
	logic [23:0]  f_q;
	logic [23:0]  x_q;
	logic         force_q;
	logic [7:0]   ovr_q;
	logic [19:0]  q1_q;
	logic [16:0]  q2_q;
	logic [9:0]   q4_q;
	logic [6:0]   q5_q;

	logic [7:0]   last_band_q;
	logic [10:0]  last_khz_q;
	logic [9:0]   last_coarse_q;
	logic [3:0]   last_ones_q;

	logic [47:0]  prod;
	logic [stws_pkg::QUOT_W-1:0] quot;
	logic [23:0]  f_hi, f_clamp;
	logic [3:0]   d0, d1, d4;
	logic [9:0]   khz_raw, khz_fold;
	logic [10:0]  khz;
	logic [7:0]   div5, band;
	logic [11:0]  w12;
	logic [7:0]   eff_band;
	logic [10:0]  eff_khz;
	logic [9:0]   eff_coarse;
	logic [3:0]   eff_ones;
	logic         wr_band;

	// Shared divide-by-ten step
	assign prod = {24'd0, x_q} * {24'd0, stws_pkg::RECIP10};
	assign quot = prod[stws_pkg::RECIP_SHIFT +: stws_pkg::QUOT_W];

	assign f_hi    = (f_q > hi_lim) ? hi_lim : f_q;
	assign f_clamp = (f_hi < lo_lim) ? lo_lim : f_hi;

	// Digits by subtracting ten times the next quotient, low bits only
	assign d0 = f_q[3:0]  - {q1_q[2:0], 1'b0} - {q1_q[0], 3'b000};
	assign d1 = q1_q[3:0] - {q2_q[2:0], 1'b0} - {q2_q[0], 3'b000};
	assign d4 = q4_q[3:0] - {q5_q[2:0], 1'b0} - {q5_q[0], 3'b000};

	assign khz_raw  = q2_q[9:0] - 10'({3'b000, q5_q} * stws_pkg::THOUSAND);
	assign khz_fold = (khz_raw >= stws_pkg::KHZ_FOLD) ? khz_raw - stws_pkg::KHZ_FOLD : khz_raw;
	assign khz      = {1'b0, khz_fold} + stws_pkg::KHZ_BASE;

	// Coarse count over five from its last decimal digit
	assign div5 = {q5_q, 1'b0} + {7'd0, (d4 >= 4'd5)};

	assign band = (ovr_q == stws_pkg::BAND_AUTO) ? stws_pkg::auto_band(f_q) : ovr_q;
	assign w12  = (band < stws_pkg::BAND_SPLIT) ? {4'd0, div5} + stws_pkg::SYN2_LOW_ADD
	                                            : {4'd0, div5} - stws_pkg::SYN2_HIGH_SUB;

	assign eff_band   = force_q ? '0 : last_band_q;
	assign eff_khz    = force_q ? '0 : last_khz_q;
	assign eff_coarse = force_q ? '0 : last_coarse_q;
	assign wr_band    = (band != eff_band);
	assign eff_ones   = (force_q || wr_band) ? '0 : last_ones_q;

	always_comb begin
		q_desc.clamped_frequency = f_q;
		q_desc.band              = band;
		q_desc.khz               = khz;
		q_desc.syn2_hi           = stws_pkg::LATCH_A1 + w12[11:4];
		q_desc.syn2_lo           = w12[3:0];
		q_desc.ones              = d0;
		q_desc.hundreds          = d1;
		q_desc.wr_band           = wr_band;
		q_desc.wr_syn1           = (khz != eff_khz);
		q_desc.wr_syn2           = (q4_q != eff_coarse);
		q_desc.wr_preset         = (d0 != eff_ones);
	end

	assign q_push = (state_q == ST_FINAL) && !q_full;
	assign full   = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				f_q     <= item.frequency;
				force_q <= item.force_req;
				ovr_q   <= item.band_override;
			end
			ST_CLAMP: begin
				f_q <= f_clamp;
				x_q <= f_clamp;
			end
			ST_DIV: begin
				x_q <= 24'(quot);
				case (step_q)
					3'd0:    q1_q <= quot[19:0];
					3'd1:    q2_q <= quot[16:0];
					3'd3:    q4_q <= quot[9:0];
					3'd4:    q5_q <= quot[6:0];
					default: ;
				endcase
			end
			ST_FINAL: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			last_band_q   <= '0;
			last_khz_q    <= '0;
			last_coarse_q <= '0;
			last_ones_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (push) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DivLast) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					// every remembered value ends equal to this item's value
					if (!q_full) begin
						last_band_q   <= band;
						last_khz_q    <= khz;
						last_coarse_q <= q4_q;
						last_ones_q   <= d0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> sv/stws_back.sv
// Back end: walk an item's latch writes, a result per cycle unless stalled.
module stws_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  stws_pkg::desc_t     q_desc,
	input  logic                pop,
	output logic                empty,
	output stws_pkg::out_item_t result
);

	localparam logic [3:0] SLOT_BAND   = 4'd0;
	localparam logic [3:0] SLOT_S1_A3  = 4'd1;
	localparam logic [3:0] SLOT_S1_A2  = 4'd2;
	localparam logic [3:0] SLOT_S1_A1  = 4'd3;
	localparam logic [3:0] SLOT_S1_A0  = 4'd4;
	localparam logic [3:0] SLOT_S2_A3  = 4'd5;
	localparam logic [3:0] SLOT_S2_A2  = 4'd6;
	localparam logic [3:0] SLOT_S2_A1  = 4'd7;
	localparam logic [3:0] SLOT_S2_A0  = 4'd8;
	localparam logic [3:0] SLOT_PRESET = 4'd9;
	localparam logic [3:0] SLOT_DATA   = 4'd10;

	stws_pkg::desc_t     cur_q;
	logic                cur_valid_q;
	logic [10:0]         rem_q;
	logic [10:0]         rem_clr;
	stws_pkg::out_item_t out_q;
	logic                out_valid_q;
	stws_pkg::out_item_t res_next;
	logic [3:0]          slot;
	logic                is_last, adv, load;

	// Lowest pending slot goes next
	always_comb begin
		slot = SLOT_DATA;
		for (int i = 10; i >= 0; i--) begin
			if (rem_q[i]) begin
				slot = 4'(i);
			end
		end
	end

	assign rem_clr = rem_q & (rem_q - 11'd1);
	assign is_last = (rem_clr == '0);
	assign adv     = cur_valid_q && (!out_valid_q || pop);
	assign load    = !q_empty && (!cur_valid_q || (adv && is_last));
	assign q_pop   = load;

	always_comb begin
		res_next.clamped_frequency = cur_q.clamped_frequency;
		res_next.last              = is_last;
		res_next.target            = stws_pkg::TGT_DATA;
		res_next.data              = stws_pkg::DIGIT_BASE + {4'd0, cur_q.hundreds};
		unique case (slot)
			SLOT_BAND: begin
				res_next.target = stws_pkg::TGT_BAND;
				res_next.data   = cur_q.band;
			end
			SLOT_S1_A3: begin
				res_next.target = stws_pkg::TGT_SYN1;
				res_next.data   = stws_pkg::LATCH_A3;
			end
			SLOT_S1_A2: begin
				res_next.target = stws_pkg::TGT_SYN1;
				res_next.data   = stws_pkg::LATCH_A2 + {5'd0, cur_q.khz[10:8]};
			end
			SLOT_S1_A1: begin
				res_next.target = stws_pkg::TGT_SYN1;
				res_next.data   = stws_pkg::LATCH_A1 + {4'd0, cur_q.khz[7:4]};
			end
			SLOT_S1_A0: begin
				res_next.target = stws_pkg::TGT_SYN1;
				res_next.data   = {4'd0, cur_q.khz[3:0]};
			end
			SLOT_S2_A3: begin
				res_next.target = stws_pkg::TGT_SYN2;
				res_next.data   = stws_pkg::LATCH_A3;
			end
			SLOT_S2_A2: begin
				res_next.target = stws_pkg::TGT_SYN2;
				res_next.data   = stws_pkg::LATCH_A2;
			end
			SLOT_S2_A1: begin
				res_next.target = stws_pkg::TGT_SYN2;
				res_next.data   = cur_q.syn2_hi;
			end
			SLOT_S2_A0: begin
				res_next.target = stws_pkg::TGT_SYN2;
				res_next.data   = {4'd0, cur_q.syn2_lo};
			end
			SLOT_PRESET: begin
				res_next.target = stws_pkg::TGT_PRESET;
				res_next.data   = stws_pkg::DIGIT_BASE + {4'd0, cur_q.ones};
			end
			default: ;
		endcase
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_desc;
		end
		if (adv) begin
			out_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
				rem_q       <= {1'b1, q_desc.wr_preset, {4{q_desc.wr_syn2}},
				                {4{q_desc.wr_syn1}}, q_desc.wr_band};
			end else if (adv && is_last) begin
				cur_valid_q <= 1'b0;
				rem_q       <= '0;
			end else if (adv) begin
				rem_q <= rem_clr;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/synth_tuning_word_sequencer_unit.sv
// Top level of the tuning word sequencer: config registers, front, queue and back.
//
//  channel   handshake            payload     direction
//  input     push / full          item        in
//  result    pop / empty          result      out
//  config    psel penable pwrite  paddr/pwdata/prdata, pready tied high
//
// The front takes one item at a time, holding full until it is done: accept, clamp,
// five shared divide-by-ten steps, then classification and a transfer into the queue,
// which waits while the queue is full. The back gives one result per cycle while the
// result register is free or popped, 1 to 11 per item; the slower side sets the sustained rate.
// Reset clears control state and the remembered latch values; no clearing pass.
// Either side may stall: the queue and the result register absorb it.
`include "synth_tuning_word_sequencer_unit_defines.svh"

module synth_tuning_word_sequencer_unit #(
	parameter int unsigned FifoDepth = stws_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input queue side
	input  logic                           push,
	output logic                           full,
	input  stws_pkg::in_item_t             item,
	// result queue side
	input  logic                           pop,
	output logic                           empty,
	output stws_pkg::out_item_t            result,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [stws_pkg::PADDR_W-1:0]   paddr,
	input  logic [stws_pkg::PDATA_W-1:0]   pwdata,
	output logic [stws_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	logic [23:0]     min_freq_q, max_freq_q;
	logic [23:0]     lo_lim_q, hi_lim_q;
	logic [23:0]     wr_val, wr_capped;
	logic            cfg_wr;

	logic            q_push, q_full, q_pop, q_empty;
	stws_pkg::desc_t q_wr_desc, q_rd_desc;

	// Configuration: complete a write in the access phase, decode on bit 2
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign wr_val    = pwdata[23:0];
	// Hold limits capped to FREQ_CAP so every clamped frequency stays at or below it
	assign wr_capped = (wr_val > stws_pkg::FREQ_CAP) ? stws_pkg::FREQ_CAP : wr_val;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			stws_pkg::REG_MIN: prdata = {8'd0, min_freq_q};
			stws_pkg::REG_MAX: prdata = {8'd0, max_freq_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_freq_q <= stws_pkg::MIN_FREQ_RST;
			max_freq_q <= stws_pkg::MAX_FREQ_RST;
			lo_lim_q   <= stws_pkg::MIN_FREQ_RST;
			hi_lim_q   <= stws_pkg::MAX_FREQ_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				stws_pkg::REG_MIN: begin
					min_freq_q <= wr_val;
					lo_lim_q   <= wr_capped;
				end
				stws_pkg::REG_MAX: begin
					max_freq_q <= wr_val;
					hi_lim_q   <= wr_capped;
				end
			endcase
		end
	end

	// Front: accept and classify, one item at a time
	stws_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.lo_lim (lo_lim_q),
		.hi_lim (hi_lim_q),
		.q_push (q_push),
		.q_full (q_full),
		.q_desc (q_wr_desc)
	);

	// Queue decouples classification from write sequencing
	stws_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr_desc),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (q_rd_desc),
		.empty   (q_empty)
	);

	// Back: sequence the latch writes into the result register
	stws_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_desc  (q_rd_desc),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	// Never transfer into a full queue
	`STWS_ASSERT(a_no_push_full, clk, arst_n, !(q_push && q_full))
	// A transfer into the queue leaves something to read next cycle
	`STWS_ASSERT_NEXT(a_push_lands, clk, arst_n, q_push, !q_empty)
	// The data port write closes every item, and only it
	`STWS_ASSERT(a_last_is_data, clk, arst_n,
		empty || ((result.target == stws_pkg::TGT_DATA) == result.last))
	// Clamped frequency never exceeds FREQ_CAP
	`STWS_ASSERT(a_clamp_range, clk, arst_n,
		empty || (result.clamped_frequency <= stws_pkg::FREQ_CAP))

endmodule
